/* src/ebm_pkg.sv */
// Shared types and constants of the edge background mask.
`default_nettype none

package ebm_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned PixW   = 32;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [MaskW-1:0] MaskOpaque      = 8'd255;
  localparam logic [MaskW-1:0] MaskTransparent = 8'd0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_COLOR     = 2'd0,
    REG_CHANNEL_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } back_state_e;

  // A classified word as it waits in the queue.
  typedef struct packed {
    op_e             op;
    logic [PosW-1:0] col_x;
    logic [PosW-1:0] row_y;
    logic            in_range;
    logic            miss;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

/* src/ebm_front.sv */
// Front part: configuration registers, pixel classification and the word queue.
`default_nettype none

module ebm_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ebm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i,
  input  wire logic                         push_i,
  input  wire logic                         operation_i,
  input  wire logic [ebm_pkg::PosW-1:0]     col_x_i,
  input  wire logic [ebm_pkg::PosW-1:0]     row_y_i,
  input  wire logic [ebm_pkg::PixW-1:0]     pixel_value_i,
  output ebm_pkg::q_head_t                  head_o,
  input  wire logic                         pop_i,
  output logic                              full_o
);
  import ebm_pkg::*;

  localparam int unsigned Depth = 2;

  logic [PixW-1:0] key_color_q;
  logic [2:0]      channel_count_q;
  logic [PixW-1:0] cmp_mask;
  item_t           new_item;

  item_t       queue_q [Depth];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_color_q     <= '0;
      channel_count_q <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_COLOR:     key_color_q     <= cfg_wdata_i;
        REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Channels above the count take no part in the compare; counts above four saturate.
  always_comb begin
    unique case (channel_count_q)
      3'd0:    cmp_mask = 32'h0000_0000;
      3'd1:    cmp_mask = 32'h0000_00ff;
      3'd2:    cmp_mask = 32'h0000_ffff;
      3'd3:    cmp_mask = 32'h00ff_ffff;
      default: cmp_mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    new_item.op       = op_e'(operation_i);
    new_item.col_x    = col_x_i;
    new_item.row_y    = row_y_i;
    new_item.in_range = (32'(col_x_i) < 32'(MAX_DIM)) && (32'(row_y_i) < 32'(MAX_DIM));
    new_item.miss     = ((pixel_value_i ^ key_color_q) & cmp_mask) != '0;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  assign head_o.valid = count_q != '0;
  assign head_o.item  = queue_q[rd_ptr_q];
  assign full_o       = count_q == 2'(Depth);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth)) else $error("word queue over-filled");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty word queue");
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 2'd1)
    else $error("word queue count lost a push");

endmodule

`default_nettype wire

/* src/ebm_back.sv */
// Back part: row and column miss tables with read-modify-write update and mask lookup.
`default_nettype none

module ebm_back #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  ebm_pkg::q_head_t                head_i,
  output logic                            pop_o,
  output logic                            done_o,
  output logic [ebm_pkg::MaskW-1:0]       mask_value_o
);
  import ebm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned FW = $clog2(MAX_DIM + 1);
  localparam logic [FW-1:0] NoMiss = FW'(MAX_DIM);

  back_state_e state_q, state_d;
  item_t       item_q;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_row_addr, rd_col_addr, wr_row_addr, wr_col_addr;

  logic [FW-1:0] row_first_mem [MAX_DIM];
  logic [AW-1:0] row_last_mem  [MAX_DIM];
  logic [FW-1:0] col_first_mem [MAX_DIM];
  logic [AW-1:0] col_last_mem  [MAX_DIM];

  logic [FW-1:0] row_first_q, col_first_q, row_first_new, col_first_new;
  logic [AW-1:0] row_last_q, col_last_q, row_last_new, col_last_new;
  logic [31:0]   pos_x, pos_y;
  logic          opaque;
  logic          done_q;
  logic [MaskW-1:0] mask_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (head_i.valid) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        pop_o = head_i.valid;
        rd_en = head_i.valid;
      end
      S_EXEC:  wr_en = (item_q.op == OP_LOAD) && item_q.in_range;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i.item;
    end
  end

  // Addresses are the positions cut to the table depth; out-of-range words are never written into it.
  always_comb begin
    logic [31:0] hx, hy;
    hx = 32'(head_i.item.col_x);
    hy = 32'(head_i.item.row_y);
    rd_col_addr = hx[AW-1:0];
    rd_row_addr = hy[AW-1:0];
    wr_col_addr = pos_x[AW-1:0];
    wr_row_addr = pos_y[AW-1:0];
  end

  assign pos_x = 32'(item_q.col_x);
  assign pos_y = 32'(item_q.row_y);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      row_first_q <= row_first_mem[rd_row_addr];
      row_last_q  <= row_last_mem[rd_row_addr];
    end
    if (wr_en) begin
      row_first_mem[wr_row_addr] <= row_first_new;
      row_last_mem[wr_row_addr]  <= row_last_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      col_first_q <= col_first_mem[rd_col_addr];
      col_last_q  <= col_last_mem[rd_col_addr];
    end
    if (wr_en) begin
      col_first_mem[wr_col_addr] <= col_first_new;
      col_last_mem[wr_col_addr]  <= col_last_new;
    end
  end

  // A word at position zero starts its row or column afresh; later misses widen the span.
  always_comb begin
    row_first_new = row_first_q;
    row_last_new  = row_last_q;
    col_first_new = col_first_q;
    col_last_new  = col_last_q;
    if (pos_x == '0) begin
      row_first_new = item_q.miss ? '0 : NoMiss;
      row_last_new  = '0;
    end else if (item_q.miss) begin
      if (pos_x < 32'(row_first_q)) row_first_new = FW'(pos_x);
      if (pos_x > 32'(row_last_q))  row_last_new  = AW'(pos_x);
    end
    if (pos_y == '0) begin
      col_first_new = item_q.miss ? '0 : NoMiss;
      col_last_new  = '0;
    end else if (item_q.miss) begin
      if (pos_y < 32'(col_first_q)) col_first_new = FW'(pos_y);
      if (pos_y > 32'(col_last_q))  col_last_new  = AW'(pos_y);
    end
  end

  assign opaque = item_q.in_range &&
                  !(pos_x < 32'(row_first_q) || pos_x > 32'(row_last_q) ||
                    pos_y < 32'(col_first_q) || pos_y > 32'(col_last_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC) && (item_q.op == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= opaque ? MaskOpaque : MaskTransparent;
  end

  assign done_o       = done_q;
  assign mask_value_o = mask_q;

  a_exec_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $past(state_q == S_IDLE))
    else $error("execute step entered without a table read");
  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_EXEC && item_q.op == OP_READ))
    else $error("result strobe without a read word");
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !rd_en) else $error("table write and read in the same cycle");

endmodule

`default_nettype wire

/* src/edge_background_mask.sv */
// Top level of the edge background mask: front classifier, word queue and table back end.
//
//   channel   handshake            payload
//   command   start / busy         operation_i, col_x_i, row_y_i, pixel_value_i
//   result    done_o (one cycle)   mask_value_o
//   config    cfg_we_i, cfg_idx_i  cfg_wdata_i
//
// In the back end each word first reads the row and column tables in S_IDLE, then in
// S_EXEC updates them or evaluates the mask; the back end takes no new word until it is
// through with the last one. A read answers on done_o, with mask_value_o, once its word
// has read the tables in S_IDLE, passed S_EXEC and been registered into done_q and mask_q.
// busy is high while the two-word queue is full. Reset clears control state only; the
// tables hold nothing meaningful until written and need no clearing pass.
`default_nettype none

module edge_background_mask #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ebm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [31:0]                  cfg_wdata_i,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         operation_i,
  input  wire logic [ebm_pkg::PosW-1:0]     col_x_i,
  input  wire logic [ebm_pkg::PosW-1:0]     row_y_i,
  input  wire logic [ebm_pkg::PixW-1:0]     pixel_value_i,
  output logic                              done_o,
  output logic [ebm_pkg::MaskW-1:0]         mask_value_o
);
  import ebm_pkg::*;

  q_head_t head;
  logic    pop, full;

  ebm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (start && !full),
    .operation_i   (operation_i),
    .col_x_i       (col_x_i),
    .row_y_i       (row_y_i),
    .pixel_value_i (pixel_value_i),
    .head_o        (head),
    .pop_i         (pop),
    .full_o        (full)
  );

  ebm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .done_o       (done_o),
    .mask_value_o (mask_value_o)
  );

  assign busy = full;

endmodule

`default_nettype wire
